FILE: hdl/rcm_pkg.sv
// Package for the mod-65535 recurrence checksum block.
// Holds the term, index and state types and the recurrence constants.
// Depends on nothing.
package rcm_pkg;

  localparam int TERM_W       = 16;
  localparam int IDX_W        = 8;
  localparam int BYTE_W       = 8;
  localparam int WEIGHT_A     = 17;
  localparam int WEIGHT_B     = 31;
  localparam int FIRST_OFFSET = 7;
  localparam logic [TERM_W-1:0] TERM_MOD = 16'hFFFF;

  typedef logic [TERM_W-1:0] term_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    term_t older;
    term_t newer;
    idx_t  index;
  } rcm_state_t;

endpackage

FILE: hdl/rcm_term_calc.sv
// Next-state logic of the checksum recurrence: weights, two products,
// signed difference folded mod 65535 with the unsigned wrap correction.
// Depends on rcm_pkg.
module rcm_term_calc (
  input  rcm_pkg::rcm_state_t state_cur,
  input  rcm_pkg::byte_t      data_byte,
  input  logic                first_byte,
  output rcm_pkg::rcm_state_t state_nxt
);
  import rcm_pkg::*;

  logic [12:0] a_prod;
  logic [12:0] b_prod;
  logic [8:0]  mult_l;
  logic [24:0] plus_v;
  logic [24:0] minus_v;
  logic [24:0] diff_v;
  logic        neg;
  logic [16:0] fold_v;
  term_t       resid;
  term_t       term_v;

  assign a_prod  = {5'd0, state_cur.index} * 13'(WEIGHT_A);
  assign b_prod  = {5'd0, state_cur.index} * 13'(WEIGHT_B);
  assign mult_l  = {1'b0, data_byte} + {1'b0, a_prod[7:0]};
  assign plus_v  = {16'd0, mult_l} * {9'd0, state_cur.newer};
  assign minus_v = {17'd0, b_prod[7:0]} * {9'd0, state_cur.older};
  assign neg     = plus_v < minus_v;
  assign diff_v  = neg ? (minus_v - plus_v) : (plus_v - minus_v);
  assign fold_v  = {8'd0, diff_v[24:16]} + {1'b0, diff_v[15:0]};

  always_comb begin
    if (fold_v >= {1'b0, TERM_MOD}) begin
      resid = 16'(fold_v - {1'b0, TERM_MOD});
    end else begin
      resid = fold_v[15:0];
    end
    if (!neg) begin
      term_v = resid;
    end else if (resid <= 16'd1) begin
      term_v = 16'd1 - resid;
    end else begin
      term_v = 16'(17'h10000 - {1'b0, resid});
    end
  end

  always_comb begin
    if (first_byte) begin
      state_nxt.older = 16'd1;
      state_nxt.newer = {8'd0, data_byte} + 16'(FIRST_OFFSET);
      state_nxt.index = 8'd1;
    end else begin
      state_nxt.older = state_cur.newer;
      state_nxt.newer = term_v;
      state_nxt.index = state_cur.index + 8'd1;
    end
  end

endmodule

FILE: hdl/rcm_out_reg.sv
// Output register of the checksum block with valid/stall handshake.
// Loads a finished checksum and holds it until the transaction completes.
// Depends on rcm_pkg.
module rcm_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  rcm_pkg::term_t load_value,
  input  logic          out_stall,
  output logic          out_valid,
  output rcm_pkg::term_t out_checksum
);
  import rcm_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  term_t value_r;

  always_comb begin
    priority if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= load_value;
    end
  end

  assign out_valid    = valid_r;
  assign out_checksum = value_r;

endmodule

FILE: hdl/recurrence_checksum_mod65535.sv
// A last-marked byte is held in s1, then its checksum loads the output register.
// Throughput: one byte per cycle; the term unit updates the two terms and the
// index combinationally, so each byte sees the state left by the one before.
// Only a last-marked byte waiting on a stalled output register stalls input.
// Reset (rst_n low, synchronous): terms to 1, index to 0, no byte or result held.
module recurrence_checksum_mod65535 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rcm_pkg::byte_t in_data_byte,
  input  logic           in_first_byte,
  input  logic           in_last_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output rcm_pkg::term_t out_checksum
);
  import rcm_pkg::*;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  byte_t      s1_byte_r;
  logic       s1_first_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       in_take;
  rcm_state_t state_r;
  rcm_state_t state_nxt;

  assign s1_go    = s1_valid_r && !(s1_last_r && out_valid && out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    priority if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= '{older: 16'd1, newer: 16'd1, index: 8'd0};
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_go) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_data_byte;
      s1_first_r <= in_first_byte;
      s1_last_r  <= in_last_byte;
    end
  end

  rcm_term_calc u_term (
    .state_cur  (state_r),
    .data_byte  (s1_byte_r),
    .first_byte (s1_first_r),
    .state_nxt  (state_nxt)
  );

  rcm_out_reg u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (s1_go && s1_last_r),
    .load_value   (state_nxt.newer),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_checksum (out_checksum)
  );

endmodule

FILE: hdl/rcm_checker.sv
// Port-level checks for the recurrence checksum block, bound to its top level.
// Depends on rcm_pkg and recurrence_checksum_mod65535.
module rcm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input rcm_pkg::byte_t in_data_byte,
  input logic           in_first_byte,
  input logic           in_last_byte,
  input logic           out_valid,
  input logic           out_stall,
  input rcm_pkg::term_t out_checksum
);
  import rcm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_checksum))
    else $error("stalled result changed or dropped");

  a_residue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_checksum != TERM_MOD)
    else $error("checksum not reduced mod 65535");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_first_byte && in_last_byte
      ##1 !(out_valid && out_stall)
      |=> out_valid && out_checksum == ({8'd0, $past(in_data_byte, 2)} + 16'd7))
    else $error("single-byte message gave wrong checksum");

endmodule

bind recurrence_checksum_mod65535 rcm_checker u_rcm_checker (.*);

FILE: test/recurrence_checksum_mod65535_check.sv
`timescale 1ns / 100ps
// Checker for the mod-65535 recurrence checksum block: watches both channels,
// predicts each message checksum and compares it with what comes out.
// Depends on rcm_pkg for the byte, term and index types and the weights.
module recurrence_checksum_mod65535_check (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  rcm_pkg::byte_t in_data_byte,
  input  logic           in_first_byte,
  input  logic           in_last_byte,
  input  logic           out_valid,
  input  logic           out_stall,
  input  rcm_pkg::term_t out_checksum,
  output int             errors,
  output int             pending
);
  import rcm_pkg::*;

  term_t older_sum;
  term_t newer_sum;
  idx_t  position;
  term_t checksum_q[$];
  int    fault_count;

  function automatic term_t fold_byte(byte_t data, idx_t pos, term_t newer, term_t older);
    logic [63:0] wa;
    logic [63:0] wb;
    logic [63:0] gain;
    logic [63:0] loss;
    wa   = (64'(WEIGHT_A) * 64'(pos)) & 64'hFF;
    wb   = (64'(WEIGHT_B) * 64'(pos)) & 64'hFF;
    gain = (64'(data) + wa) * 64'(newer);
    loss = wb * 64'(older);
    // unsigned wrap of a negative difference adds one mod 65535
    return term_t'((gain - loss) % 64'(TERM_MOD));
  endfunction

  always @(posedge clk) begin : watch
    term_t fresh;
    term_t want;
    if (!rst_n) begin
      older_sum   = term_t'(1);
      newer_sum   = term_t'(1);
      position    = '0;
      fault_count = 0;
      checksum_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (checksum_q.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected checksum transaction: expected none, actual %0d",
                   $time, out_checksum);
        end else begin
          want = checksum_q.pop_front();
          if (out_checksum !== want) begin
            fault_count++;
            $display("%0t: checksum mismatch: expected %0d, actual %0d",
                     $time, want, out_checksum);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_first_byte) begin
          older_sum = term_t'(1);
          newer_sum = term_t'(in_data_byte) + term_t'(FIRST_OFFSET);
          position  = idx_t'(1);
        end else begin
          fresh     = fold_byte(in_data_byte, position, newer_sum, older_sum);
          older_sum = newer_sum;
          newer_sum = fresh;
          position  = position + 1'b1;
        end
        if (in_last_byte) checksum_q.push_back(newer_sum);
      end
    end
    errors  <= fault_count;
    pending <= checksum_q.size();
  end

endmodule

FILE: test/recurrence_checksum_mod65535_test.sv
`timescale 1ns / 100ps
// Top of the recurrence checksum testbench: drives marked byte messages and
// random output stalls, and gives the verdict. Depends on rcm_pkg, the block
// and recurrence_checksum_mod65535_check.
module recurrence_checksum_mod65535_test;
  import rcm_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic  clk           = 1'b0;
  logic  rst_n         = 1'b0;
  logic  in_valid      = 1'b0;
  logic  in_stall;
  byte_t in_data_byte  = '0;
  logic  in_first_byte = 1'b0;
  logic  in_last_byte  = 1'b0;
  logic  out_valid;
  logic  out_stall     = 1'b0;
  term_t out_checksum;
  int    errors;
  int    pending;
  int    sent          = 0;
  int    cycle         = 0;
  int    quiet         = 0;

  recurrence_checksum_mod65535 DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_first_byte(in_first_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum)
  );

  recurrence_checksum_mod65535_check score (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_first_byte(in_first_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst_n || (cycle >= 400 && cycle < 800)) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 6);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(byte_t data, bit first, bit last);
    if (!(sent >= 450 && sent < 700) && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= data;
    in_first_byte <= first;
    in_last_byte  <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic send_message(int len);
    for (int k = 0; k < len; k++) begin
      send_byte(byte_t'($urandom_range(255)), k == 0, k == len - 1);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int goal;
    int pick;
    bit paused;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // continue from reset state without a start mark
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    // continue after a finished message
    send_byte(8'h00, 1'b0, 1'b1);
    // restart in the middle of a message
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'h34, 1'b1, 1'b0);
    send_byte(8'h56, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    repeat (6) send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    drain();

    // cross the index wrap at least once
    send_message(300);
    goal   = 1100;
    paused = 1'b0;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_byte(byte_t'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else if (pick < 10 && sent + 300 < goal) begin
        send_message($urandom_range(300, 256));
      end else begin
        send_message($urandom_range(12, 1));
      end
      if (!paused && sent > goal - 500) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (pending != 0) $display("%0t: %0d checksums never arrived", $time, pending);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rcm_pkg.sv
hdl/rcm_term_calc.sv
hdl/rcm_out_reg.sv
hdl/recurrence_checksum_mod65535.sv
hdl/rcm_checker.sv
test/recurrence_checksum_mod65535_check.sv
test/recurrence_checksum_mod65535_test.sv
